FILE: rtl/utf8_to_utf16_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define U2U_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define U2U_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define U2U_ASSERT(lbl, clk, rstn, prop, msg)
`define U2U_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/u2u_pkg.sv
// Types and constants of the UTF-8 to UTF-16 decoder.
package u2u_pkg;

  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic KIND_UNIT   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_ZERO  = 2'd0,
    ST_FULL  = 2'd1,
    ST_ENDED = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] unit;
    status_e     status;
    logic [2:0]  needed_bytes;
    logic [31:0] src_count;
    logic [15:0] dst_count;
    logic        last_of_run;
  } result_t;

  // One decoded sequence or string end, as handed from front to back.
  typedef struct packed {
    logic [1:0]  nunits;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        has_status;
    status_e     status;
    logic [2:0]  need;
    logic [31:0] src;
    logic [15:0] dst_base;
  } op_t;

endpackage

FILE: rtl/u2u_front.sv
// Front end: accepts bytes, assembles sequences and classifies them into ops.
module u2u_front import u2u_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  item_t       item_i,
  input  logic [15:0] cap_i,
  output logic        op_valid_o,
  output op_t         op_o
);

  localparam logic [31:0] SEQ_OFFSET [8] = '{
    32'h0, 32'h0, 32'h3080, 32'hE2080, 32'h3C82080, 32'hFA082080, 32'h82082080, 32'h0
  };

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    priority if (b == 8'h00) len = 3'd0;
    else if (b < 8'hC0) len = 3'd1;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else len = 3'd6;
    return len;
  endfunction

  logic [2:0]  seq_total_q, seq_total_d;
  logic [2:0]  seq_seen_q, seq_seen_d;
  logic [31:0] code_accum_q, code_accum_d;
  logic [31:0] bytes_q, bytes_d;
  logic [15:0] units_q, units_d;
  logic        draining_q, draining_d;

  logic        new_seq;
  logic [2:0]  total, seen;
  logic [31:0] acc_base, acc, g, src_new;
  logic [32:0] src_wide;
  logic [19:0] v;
  logic        room1, room2, end_str, last;
  op_t         op;

  always_comb begin
    last     = item_i.last_byte;
    new_seq  = (seq_seen_q == 3'd0);
    total    = new_seq ? lead_length(item_i.byte_in) : seq_total_q;
    acc_base = new_seq ? 32'd0 : code_accum_q;
    acc      = {acc_base[25:0], 6'd0} + {24'd0, item_i.byte_in};
    seen     = (new_seq ? 3'd0 : seq_seen_q) + {2'd0, (total != 3'd0)};
    g        = acc - SEQ_OFFSET[total];
    v        = 20'(g - 32'h10000);
    src_wide = {1'b0, bytes_q} + 33'(total);
    src_new  = src_wide[32] ? 32'hFFFF_FFFF : src_wide[31:0];
    room1    = units_q < cap_i;
    room2    = ({1'b0, units_q} + 17'd1) < {1'b0, cap_i};
  end

  always_comb begin
    seq_total_d  = seq_total_q;
    seq_seen_d   = seq_seen_q;
    code_accum_d = code_accum_q;
    bytes_d      = bytes_q;
    units_d      = units_q;
    draining_d   = draining_q;
    op_valid_o   = 1'b0;
    op           = '0;
    end_str      = 1'b0;
    if (accept_i) begin
      if (draining_q) begin
        if (last) begin
          seq_total_d  = '0;
          seq_seen_d   = '0;
          code_accum_d = '0;
          bytes_d      = '0;
          units_d      = '0;
          draining_d   = 1'b0;
        end
      end else if (seen < total) begin
        if (last) begin
          op_valid_o    = 1'b1;
          op.has_status = 1'b1;
          op.status     = ST_TRUNC;
          op.need       = total;
          op.src        = bytes_q;
          op.dst_base   = units_q;
          seq_total_d   = '0;
          seq_seen_d    = '0;
          code_accum_d  = '0;
          bytes_d       = '0;
          units_d       = '0;
        end else begin
          seq_total_d  = total;
          seq_seen_d   = seen;
          code_accum_d = acc;
        end
      end else begin
        op_valid_o   = 1'b1;
        op.src       = src_new;
        op.dst_base  = units_q;
        seq_total_d  = '0;
        seq_seen_d   = '0;
        code_accum_d = '0;
        bytes_d      = src_new;
        if (!room1) begin
          op.status = ST_FULL;
          end_str   = 1'b1;
        end else if (g < 32'h10000) begin
          op.nunits = 2'd1;
          op.unit0  = g[15:0];
          if (g == 32'd0) begin
            op.status = ST_ZERO;
            end_str   = 1'b1;
          end else if (last) begin
            op.status = ST_ENDED;
            end_str   = 1'b1;
          end
        end else if (g < 32'h110000) begin
          if (!room2) begin
            op.status = ST_FULL;
            end_str   = 1'b1;
          end else begin
            op.nunits = 2'd2;
            op.unit0  = {6'b110110, v[19:10]};
            op.unit1  = {6'b110111, v[9:0]};
            if (last) begin
              op.status = ST_ENDED;
              end_str   = 1'b1;
            end
          end
        end else begin
          op.nunits = 2'd1;
          op.unit0  = 16'hFFFD;
          if (last) begin
            op.status = ST_ENDED;
            end_str   = 1'b1;
          end
        end
        units_d = units_q + 16'(op.nunits);
        if (end_str) begin
          op.has_status = 1'b1;
          if (last) begin
            bytes_d = '0;
            units_d = '0;
          end else begin
            draining_d = 1'b1;
          end
        end
      end
    end
    op_o = op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_total_q  <= '0;
      seq_seen_q   <= '0;
      code_accum_q <= '0;
      bytes_q      <= '0;
      units_q      <= '0;
      draining_q   <= 1'b0;
    end else begin
      seq_total_q  <= seq_total_d;
      seq_seen_q   <= seq_seen_d;
      code_accum_q <= code_accum_d;
      bytes_q      <= bytes_d;
      units_q      <= units_d;
      draining_q   <= draining_d;
    end
  end

endmodule

FILE: rtl/u2u_queue.sv
// Short op queue between the front end and the result generator.
`include "utf8_to_utf16_decoder_defines.svh"
module u2u_queue import u2u_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  op_t  wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output op_t  rd_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `U2U_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth), "queue overfilled")
  `U2U_ASSERT_NEVER(a_rd_empty, clk_i, rst_ni, rd_i && empty_o, "read from empty queue")

endmodule

FILE: rtl/u2u_back.sv
// Back end: expands each op into its unit and status results.
`include "utf8_to_utf16_decoder_defines.svh"
module u2u_back import u2u_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    op_valid_i,
  input  op_t     op_i,
  output logic    op_take_o,
  output logic    result_valid_o,
  output result_t result_o,
  input  logic    result_pop_i
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  result_t    result_q, result_d;
  logic       load, is_unit, is_last;
  logic [1:0] n_res;

  always_comb begin
    n_res   = op_i.nunits + {1'b0, op_i.has_status};
    load    = op_valid_i && (!valid_q || result_pop_i);
    is_unit = idx_q < op_i.nunits;
    is_last = (idx_q == n_res - 2'd1);

    result_d.kind         = is_unit ? KIND_UNIT : KIND_STATUS;
    result_d.unit         = !is_unit ? 16'd0 : ((idx_q == 2'd0) ? op_i.unit0 : op_i.unit1);
    result_d.status       = is_unit ? ST_ZERO : op_i.status;
    result_d.needed_bytes = is_unit ? 3'd0 : op_i.need;
    result_d.src_count    = op_i.src;
    result_d.dst_count    = op_i.dst_base +
                            (is_unit ? 16'(idx_q + 2'd1) : 16'(op_i.nunits));
    result_d.last_of_run  = is_last;

    op_take_o = load && is_last;
    idx_d     = idx_q;
    if (load) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
    valid_d = load || (valid_q && !result_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  `U2U_ASSERT(a_status_no_unit, clk_i, rst_ni,
              valid_q && result_q.kind == KIND_STATUS |-> result_q.unit == 16'd0,
              "status result carries a unit")
  `U2U_ASSERT(a_unit_clean, clk_i, rst_ni,
              valid_q && result_q.kind == KIND_UNIT |->
                result_q.status == ST_ZERO && result_q.needed_bytes == 3'd0,
              "unit result carries status fields")
  `U2U_ASSERT(a_need_trunc, clk_i, rst_ni,
              valid_q && result_q.needed_bytes != 3'd0 |-> result_q.status == ST_TRUNC,
              "needed_bytes outside a truncated sequence")
  `U2U_ASSERT(a_status_ends_run, clk_i, rst_ni,
              valid_q && result_q.kind == KIND_STATUS |-> result_q.last_of_run,
              "status result not last of its run")

endmodule

FILE: rtl/utf8_to_utf16_decoder.sv
// Top level of the streaming UTF-8 to UTF-16 decoder.
//
//   channel   handshake               payload
//   input     push / full             item_i   (byte_in, last_byte)
//   result    empty / pop             result_o (kind .. last_of_run)
//   config    psel/penable/pwrite     paddr, pwdata, prdata (dst_capacity at 0x0)
//
// One byte is accepted per cycle while the op queue has room; the front end decodes it
// in that cycle. The back end drives one result per cycle from a registered output while
// results are popped; a byte that yields a surrogate pair plus status gives three results.
// Sustained rate is set by the back end: results per byte, one result per cycle if popped.
// Reset clears the string state and loads dst_capacity with 0xFFFF; no clearing pass.
// full rises only when the op queue is full; a stalled result never blocks input directly.
module utf8_to_utf16_decoder import u2u_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  item_t                 item_i,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] cap_q;
  logic        accept, op_valid, q_full, q_empty, op_take, res_valid;
  op_t         op_wr, op_rd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      cap_q <= pwdata[15:0];
    end
  end

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = !res_valid;

  u2u_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cap_i      (cap_q),
    .op_valid_o (op_valid),
    .op_o       (op_wr)
  );

  u2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (op_valid),
    .wr_data_i (op_wr),
    .full_o    (q_full),
    .rd_i      (op_take),
    .rd_data_o (op_rd),
    .empty_o   (q_empty)
  );

  u2u_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (!q_empty),
    .op_i           (op_rd),
    .op_take_o      (op_take),
    .result_valid_o (res_valid),
    .result_o       (result_o),
    .result_pop_i   (pop)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder: predicted results vs. the result queue.
`timescale 1ns / 1ps

module testbench;
  import u2u_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_DST_CAPACITY = '0;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  item_t                 item_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               result_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  utf8_to_utf16_decoder u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  item_t       byte_q[$];
  result_t     decoded_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_queued = 0;
  int unsigned send_idle = 9;
  int unsigned recv_idle = 50;

  // decoder shadow state
  logic [15:0] dst_cap = 16'hFFFF;
  logic [2:0]  seq_total = '0;
  logic [2:0]  seq_seen = '0;
  logic [31:0] code_acc = '0;
  logic [31:0] bytes_done = '0;
  logic [15:0] units_out = '0;
  logic        draining = 1'b0;
  result_t     step_res[0:2];
  int          step_n = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [2:0] lead_len(logic [7:0] b);
    if (b == 8'h00) return 3'd0;
    if (b < 8'hC0) return 3'd1;
    if (b < 8'hE0) return 3'd2;
    if (b < 8'hF0) return 3'd3;
    if (b < 8'hF8) return 3'd4;
    if (b < 8'hFC) return 3'd5;
    return 3'd6;
  endfunction

  function automatic logic [31:0] len_offset(logic [2:0] len);
    case (len)
      3'd2: return 32'h0000_3080;
      3'd3: return 32'h000E_2080;
      3'd4: return 32'h03C8_2080;
      3'd5: return 32'hFA08_2080;
      3'd6: return 32'h8208_2080;
      default: return 32'h0;
    endcase
  endfunction

  function automatic void clear_string();
    seq_total  = '0;
    seq_seen   = '0;
    code_acc   = '0;
    bytes_done = '0;
    units_out  = '0;
    draining   = 1'b0;
  endfunction

  function automatic void record(logic kind, logic [15:0] u, status_e st, logic [2:0] need);
    result_t r;
    r.kind         = kind;
    r.unit         = u;
    r.status       = st;
    r.needed_bytes = need;
    r.src_count    = bytes_done;
    r.dst_count    = units_out;
    r.last_of_run  = 1'b0;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void put_unit(logic [15:0] u);
    units_out = units_out + 16'd1;
    record(KIND_UNIT, u, ST_ZERO, 3'd0);
  endfunction

  function automatic void end_string(status_e st, logic [2:0] need, logic last);
    record(KIND_STATUS, 16'h0, st, need);
    if (last) clear_string();
    else draining = 1'b1;
  endfunction

  function automatic void decode_byte(item_t it);
    logic [31:0] g;
    logic [31:0] v;
    logic [2:0]  tot;
    if (draining) begin
      if (it.last_byte) clear_string();
      return;
    end
    if (seq_seen == 3'd0) begin
      seq_total = lead_len(it.byte_in);
      code_acc  = '0;
    end
    code_acc = (code_acc << 6) + 32'(it.byte_in);
    if (seq_total != 3'd0) seq_seen++;
    if (seq_seen < seq_total) begin
      if (it.last_byte) end_string(ST_TRUNC, seq_total, 1'b1);
      return;
    end
    tot = seq_total;
    g = code_acc - len_offset(tot);
    if (bytes_done > 32'hFFFF_FFFF - 32'(tot)) bytes_done = 32'hFFFF_FFFF;
    else bytes_done = bytes_done + 32'(tot);
    seq_total = '0;
    seq_seen  = '0;
    code_acc  = '0;
    if (units_out >= dst_cap) begin
      end_string(ST_FULL, 3'd0, it.last_byte);
      return;
    end
    if (g < 32'h1_0000) begin
      put_unit(g[15:0]);
      if (g == 32'h0) begin
        end_string(ST_ZERO, 3'd0, it.last_byte);
        return;
      end
    end else if (g < 32'h11_0000) begin
      v = g - 32'h1_0000;
      if (32'(units_out) + 32'd1 >= 32'(dst_cap)) begin
        end_string(ST_FULL, 3'd0, it.last_byte);
        return;
      end
      put_unit(16'((v >> 10) - 32'h2800));
      put_unit(16'((v & 32'h3FF) - 32'h2400));
    end else begin
      put_unit(16'hFFFD);
    end
    if (it.last_byte) end_string(ST_ENDED, 3'd0, 1'b1);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        step_n = 0;
        decode_byte(byte_q.pop_front());
        if (step_n > 0) step_res[step_n-1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
      end
      if (!(push && full)) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          push   <= 1'b1;
          item_i <= byte_q[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result transaction: %p", result_o);
          errors++;
        end else begin
          exp_r = decoded_q.pop_front();
          check_field("kind", exp_r.kind, result_o.kind);
          check_field("unit", exp_r.unit, result_o.unit);
          check_field("status", exp_r.status, result_o.status);
          check_field("needed_bytes", exp_r.needed_bytes, result_o.needed_bytes);
          check_field("src_count", exp_r.src_count, result_o.src_count);
          check_field("dst_count", exp_r.dst_count, result_o.dst_count);
          check_field("last_of_run", exp_r.last_of_run, result_o.last_of_run);
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic void add_byte(logic [7:0] b, logic last);
    item_t it;
    it.byte_in   = b;
    it.last_byte = last;
    byte_q.push_back(it);
    n_queued++;
  endfunction

  function automatic logic [7:0] lead_of(int len);
    case (len)
      1: return 8'($urandom_range(1, 127));
      2: return 8'(8'hC0 + $urandom_range(31));
      3: return 8'(8'hE0 + $urandom_range(15));
      4: return 8'(8'hF0 + $urandom_range(7));
      5: return 8'(8'hF8 + $urandom_range(3));
      default: return 8'(8'hFC + $urandom_range(3));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    return 8'(8'h80 + $urandom_range(63));
  endfunction

  // one string of mostly well-formed sequences, sometimes cut mid-sequence
  function automatic void queue_string();
    logic [7:0] bq[$];
    int nch;
    int sel;
    int len;
    int keep;
    nch = $urandom_range(1, 10);
    for (int c = 0; c < nch; c++) begin
      sel = $urandom_range(99);
      if (sel < 3) len = 0;
      else if (sel < 8) len = -1;
      else if (sel < 40) len = 1;
      else if (sel < 60) len = 2;
      else if (sel < 75) len = 3;
      else if (sel < 90) len = 4;
      else if (sel < 95) len = 5;
      else len = 6;
      if (len == 0) bq.push_back(8'h00);
      else if (len < 0) bq.push_back(8'($urandom_range(255)));
      else begin
        bq.push_back(lead_of(len));
        for (int k = 1; k < len; k++) bq.push_back(cont_byte());
      end
    end
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(2, 6);
      keep = $urandom_range(1, len - 1);
      bq.push_back(lead_of(len));
      for (int k = 1; k < keep; k++) bq.push_back(cont_byte());
    end
    for (int i = 0; i < bq.size(); i++) add_byte(bq[i], i == bq.size() - 1);
  endfunction

  task automatic settle();
    while (byte_q.size() != 0 || push) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DST_CAPACITY;
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dst_cap = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("dst_capacity", val, prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned target;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset capacity
    add_byte(8'h00, 1'b1);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hC2, 1'b0); add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    for (int k = 0; k < 5; k++) add_byte(8'hBF, 1'b0);
    add_byte(8'hF8, 1'b0); add_byte(8'h88, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b1);
    add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h41, 1'b1);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
    settle();

    // output full: single unit and surrogate pair
    set_capacity(16'd1);
    add_byte(8'h41, 1'b0); add_byte(8'h42, 1'b1);
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0); add_byte(8'h80, 1'b1);
    settle();

    for (int ch = 0; ch < 6; ch++) begin
      send_idle = (ch < 2) ? 9 : (ch < 4) ? 50 : 0;
      recv_idle = (ch < 2) ? 50 : (ch < 4) ? 9 : 0;
      case (ch)
        0: set_capacity(16'hFFFF);
        1: set_capacity(16'd4);
        2: set_capacity(16'd0);
        3: set_capacity(16'd2);
        4: set_capacity(16'($urandom_range(1, 12)));
        default: set_capacity(16'($urandom_range(65535)));
      endcase
      target = n_queued + 48;
      while (n_queued < target) queue_string();
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
